// ===== design/ising_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Ising spin update package
// Field widths, beat widths, threshold register indexes and the local-field
// energy change shared by the spin update block, its checker and testbench.
// ----------------------------------------------------------------------------
package ising_pkg;

   localparam int SITE_W    = 12;
   localparam int RAND_W    = 16;
   localparam int ENERGY_W  = 16;
   localparam int MAG_W     = 14;
   localparam int COUNT_W   = 32;
   localparam int THR_W     = 16;
   localparam int NUM_THR   = 5;
   localparam int THR_IDX_W = $clog2(NUM_THR);
   localparam int CSR_IDX_W = 3;
   localparam int DE_W      = 7;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THR_DE2  = 3'd0,
      CSR_THR_DE6  = 3'd1,
      CSR_THR_DE10 = 3'd2,
      CSR_THR_DE14 = 3'd3,
      CSR_THR_DE18 = 3'd4
   } csr_index_type;

   // Energy change of flipping a spin whose four neighbors hold up_count
   // up spins: dE = -s * (8 * up_count - 14), in the range -18 to 18.
   function automatic logic [DE_W-1:0] flip_energy(input logic spin_up,
                                                   input logic [2:0] up_count);
      logic [DE_W-1:0] base;
      base = {1'b0, up_count, 3'b000} - DE_W'(14);
      return spin_up ? (DE_W'(0) - base) : base;
   endfunction

endpackage

`default_nettype wire

// ===== design/ising_metropolis_spin_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Metropolis spin update for a toroidal Ising lattice
// The req channel carries one proposal per beat: a row-major site, a 16-bit
// random fraction and a flag that clears the accept counter first. The rsp
// channel returns one beat per proposal with the accept decision and the
// energy, magnetisation and accept totals after the step. Thresholds for
// the five positive energy changes are written through the csr channel,
// which is always ready; indexes above four are ignored.
// The pipeline has four stages: input register, row/column split, lattice
// row read, and decision with write-back. A new proposal is taken every
// cycle while no waiting response stalls the pipeline.
// The lattice is kept as SIDE rows of SIDE bits in two copies so that the
// rows above, at and below a site are read in the same cycle; a write-back is
// bypassed into reads of the same row, so neighboring proposals may follow
// back to back.
// After reset, the lattice is cleared one row per cycle, and req_tready
// stays low until every row is clear. When rsp_tready is low with a beat
// waiting, the whole pipeline holds and req_tready drops.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update
   import ising_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // site_index[11:0], random_fraction[27:12], clear_accept_count[28], zero
   input  wire  [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // accepted[0], energy_now[16:1], magnetisation_now[30:17],
   // accepts_now[62:31], zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [THR_W-1:0]       csr_data
);

   localparam int RW       = $clog2(SIDE);
   localparam int NSITES   = SIDE * SIDE;
   localparam int RECIP_SH = 24;
   localparam logic [RECIP_SH-1:0] ROW_RECIP = RECIP_SH'((2**RECIP_SH + SIDE - 1) / SIDE);
   localparam logic [RW-1:0] LAST = RW'(SIDE - 1);
   localparam logic [31:0] ENERGY_INIT = 32'(3 * NSITES);
   localparam logic [31:0] MAG_INIT = 32'(0 - NSITES);

   // Configuration registers.
   logic [THR_W-1:0] thr_ff [NUM_THR];

   // Lattice clearing after reset.
   logic          clr_busy_ff;
   logic [RW-1:0] clr_row_ff;

   // Stage A: registered request.
   logic              a_valid_ff;
   logic [SITE_W-1:0] a_site_ff;
   logic [RAND_W-1:0] a_rnd_ff;
   logic              a_clear_ff;

   // Stage B: row of the site.
   logic              b_valid_ff;
   logic [SITE_W-1:0] b_site_ff;
   logic [RW-1:0]     b_row_ff;
   logic [RAND_W-1:0] b_rnd_ff;
   logic              b_clear_ff;
   logic              b_in_range_ff;

   // Stage C: lattice rows and neighbor positions.
   logic              c_valid_ff;
   logic [RW-1:0]     c_row_ff;
   logic [RW-1:0]     c_col_ff;
   logic [RW-1:0]     c_lf_ff;
   logic [RW-1:0]     c_rt_ff;
   logic [RAND_W-1:0] c_rnd_ff;
   logic              c_clear_ff;
   logic              c_in_range_ff;
   logic [SIDE-1:0]   rd_up_ff;
   logic [SIDE-1:0]   rd_mid_ff;
   logic [SIDE-1:0]   rd_dn_ff;

   // Totals and response.
   logic [ENERGY_W-1:0]    energy_ff;
   logic [MAG_W-1:0]       mag_ff;
   logic [COUNT_W-1:0]     acc_cnt_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // Two copies of the lattice, one row per word.
   logic [SIDE-1:0] lat_a [SIDE];
   logic [SIDE-1:0] lat_b [SIDE];

   logic                  pipe_adv;
   logic                  req_fire;
   logic [SITE_W+RECIP_SH-1:0] row_prod;
   logic                  a_in_range;
   logic [RW-1:0]         b_row_in;
   logic [SITE_W-1:0]     col_full;
   logic [RW-1:0]         b_col;
   logic [RW-1:0]         b_up;
   logic [RW-1:0]         b_dn;
   logic [RW-1:0]         b_lf;
   logic [RW-1:0]         b_rt;
   logic                  c_spin;
   logic [2:0]            c_up_count;
   logic [DE_W-1:0]       c_de;
   logic                  c_de_pos;
   logic [DE_W-1:0]       c_de_off;
   logic [THR_IDX_W-1:0]  c_thr_idx;
   logic [THR_W-1:0]      c_thr;
   logic                  c_flip;
   logic [COUNT_W-1:0]    cnt_base;
   logic [COUNT_W-1:0]    acc_cnt_in;
   logic [ENERGY_W-1:0]   energy_in;
   logic [MAG_W-1:0]      mag_in;
   logic                  wr_en;
   logic [RW-1:0]         wr_row;
   logic [SIDE-1:0]       wr_data;

   assign pipe_adv   = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_adv && !clr_busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Row by reciprocal multiplication, exact for every site inside the lattice; sites outside it get row zero.
   always_comb begin
      a_in_range = {5'd0, a_site_ff} < 17'(NSITES);
      row_prod   = a_site_ff * ROW_RECIP;
      b_row_in   = a_in_range ? row_prod[RECIP_SH +: RW] : '0;
   end

   always_comb begin
      col_full = b_site_ff - SITE_W'(b_row_ff * SIDE);
      b_col    = col_full[RW-1:0];
      b_up     = (b_row_ff == '0) ? LAST : b_row_ff - RW'(1);
      b_dn     = (b_row_ff == LAST) ? '0 : b_row_ff + RW'(1);
      b_lf     = (b_col == '0) ? LAST : b_col - RW'(1);
      b_rt     = (b_col == LAST) ? '0 : b_col + RW'(1);
   end

   always_comb begin
      c_spin     = rd_mid_ff[c_col_ff];
      c_up_count = 3'(rd_up_ff[c_col_ff]) + 3'(rd_dn_ff[c_col_ff])
                 + 3'(rd_mid_ff[c_lf_ff]) + 3'(rd_mid_ff[c_rt_ff]);
      c_de       = flip_energy(c_spin, c_up_count);
      c_de_pos   = !c_de[DE_W-1] && (c_de != '0);
      c_de_off   = (c_de - DE_W'(2)) >> 2;
      c_thr_idx  = c_de_off[THR_IDX_W-1:0];
      c_thr      = (32'(c_thr_idx) < NUM_THR) ? thr_ff[c_thr_idx] : '0;
      c_flip     = c_in_range_ff && (!c_de_pos || (c_rnd_ff < c_thr));
      cnt_base   = c_clear_ff ? '0 : acc_cnt_ff;
      acc_cnt_in = (c_flip && cnt_base != '1) ? cnt_base + COUNT_W'(1) : cnt_base;
      energy_in  = c_flip ? energy_ff + {{(ENERGY_W-DE_W){c_de[DE_W-1]}}, c_de}
                          : energy_ff;
      mag_in     = c_flip ? mag_ff + (c_spin ? MAG_W'(-2) : MAG_W'(2)) : mag_ff;
   end

   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_row  = clr_row_ff;
         wr_data = '0;
      end else begin
         wr_en   = pipe_adv && c_valid_ff && c_flip;
         wr_row  = c_row_ff;
         wr_data = rd_mid_ff ^ (SIDE'(1) << c_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lat_a[wr_row] <= wr_data;
      end
      if (pipe_adv) begin
         rd_up_ff  <= (wr_en && wr_row == b_up) ? wr_data : lat_a[b_up];
         rd_mid_ff <= (wr_en && wr_row == b_row_ff) ? wr_data : lat_a[b_row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lat_b[wr_row] <= wr_data;
      end
      if (pipe_adv) begin
         rd_dn_ff <= (wr_en && wr_row == b_dn) ? wr_data : lat_b[b_dn];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_THR; i++) begin
            thr_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THR_DE2:  thr_ff[0] <= csr_data;
            CSR_THR_DE6:  thr_ff[1] <= csr_data;
            CSR_THR_DE10: thr_ff[2] <= csr_data;
            CSR_THR_DE14: thr_ff[3] <= csr_data;
            CSR_THR_DE18: thr_ff[4] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + RW'(1);
         if (clr_row_ff == LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= ENERGY_INIT[ENERGY_W-1:0];
         mag_ff       <= MAG_INIT[MAG_W-1:0];
         acc_cnt_ff   <= '0;
      end else if (pipe_adv) begin
         a_valid_ff   <= req_fire;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
         if (c_valid_ff) begin
            energy_ff  <= energy_in;
            mag_ff     <= mag_in;
            acc_cnt_ff <= acc_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         a_site_ff     <= req_tdata[SITE_W-1:0];
         a_rnd_ff      <= req_tdata[SITE_W +: RAND_W];
         a_clear_ff    <= req_tdata[SITE_W+RAND_W];
         b_site_ff     <= a_site_ff;
         b_row_ff      <= b_row_in;
         b_rnd_ff      <= a_rnd_ff;
         b_clear_ff    <= a_clear_ff;
         b_in_range_ff <= a_in_range;
         c_row_ff      <= b_row_ff;
         c_col_ff      <= b_col;
         c_lf_ff       <= b_lf;
         c_rt_ff       <= b_rt;
         c_rnd_ff      <= b_rnd_ff;
         c_clear_ff    <= b_clear_ff;
         c_in_range_ff <= b_in_range_ff;
         rsp_data_ff   <= {1'b0, acc_cnt_in, mag_in, energy_in, c_flip};
      end
   end

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("Request taken while the lattice is being cleared.");

   a_write_from_live_item: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !clr_busy_ff) |-> (c_valid_ff && c_in_range_ff))
      else $error("Lattice write without a live in-range proposal.");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      (pipe_adv && c_valid_ff && !c_clear_ff && acc_cnt_ff == '1) |=> (acc_cnt_ff == '1))
      else $error("Accept counter wrapped.");

   a_mag_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(mag_ff) |-> ((mag_ff - $past(mag_ff)) == MAG_W'(2)
                         || (mag_ff - $past(mag_ff)) == MAG_W'(-2)))
      else $error("Magnetisation moved by other than two.");

endmodule

`default_nettype wire

// ===== verif/ising_metropolis_spin_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spin update checker
// Watches the req, rsp and csr channels of the Metropolis spin update block.
// It keeps its own lattice, totals and thresholds, predicts the response of
// every accepted req beat, and compares each rsp beat field by field with
// the oldest prediction. The count of failures and of responses still due
// is handed to the testbench top.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_checker
   import ising_pkg::*;
#(
   parameter int SIDE = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_tready,
   input  wire  [REQ_TDATA_W-1:0] req_tdata,
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire  [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire                    csr_valid,
   input  wire                    csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [THR_W-1:0]       csr_data,
   output int unsigned            outstanding,
   output int unsigned            failures
);

   localparam int NUM_SITES = SIDE * SIDE;

   typedef struct packed {
      logic [COUNT_W-1:0]  accepts;
      logic [MAG_W-1:0]    magnet;
      logic [ENERGY_W-1:0] energy;
      logic                accepted;
   } spin_result_type;

   logic                spins [NUM_SITES];
   logic [ENERGY_W-1:0] energy_total;
   logic [MAG_W-1:0]    magnet_total;
   logic [COUNT_W-1:0]  accept_total;
   logic [THR_W-1:0]    thresholds [NUM_THR];
   spin_result_type     results_due [$];
   int unsigned         fail_count = 0;

   function automatic int spin_at(int row, int col);
      return spins[row * SIDE + col] ? 1 : -1;
   endfunction

   task automatic predict_flip(input logic [SITE_W-1:0] site,
                               input logic [RAND_W-1:0] rnd,
                               input logic clear,
                               output spin_result_type res);
      int row, col, s, near, de, k;
      logic take;
      take = 1'b0;
      if (clear)
         accept_total = '0;
      if (int'(site) < NUM_SITES) begin
         row  = int'(site) / SIDE;
         col  = int'(site) % SIDE;
         s    = spin_at(row, col);
         near = spin_at((row + SIDE - 1) % SIDE, col) + spin_at((row + 1) % SIDE, col)
              + spin_at(row, (col + SIDE - 1) % SIDE) + spin_at(row, (col + 1) % SIDE);
         de   = -s * (4 * near + 2);
         if (de <= 0) begin
            take = 1'b1;
         end else begin
            k = (de - 2) / 4;
            if (k < NUM_THR && rnd < thresholds[k])
               take = 1'b1;
         end
         if (take) begin
            spins[site]  = ~spins[site];
            energy_total = energy_total + ENERGY_W'(de);
            magnet_total = magnet_total + MAG_W'(-2 * s);
            if (accept_total != '1)
               accept_total = accept_total + 1'b1;
         end
      end
      res.accepted = take;
      res.energy   = energy_total;
      res.magnet   = magnet_total;
      res.accepts  = accept_total;
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      spin_result_type seen, want;
      if (reset) begin
         foreach (spins[i])
            spins[i] = 1'b0;
         foreach (thresholds[i])
            thresholds[i] = '0;
         energy_total = ENERGY_W'(3 * NUM_SITES);
         magnet_total = MAG_W'(-NUM_SITES);
         accept_total = '0;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index <= CSR_THR_DE18)
            thresholds[csr_index] = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[$bits(spin_result_type)-1:0];
            if (results_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected rsp beat, expected none, got %h", $time, seen);
            end else begin
               want = results_due.pop_front();
               check_field("accepted", want.accepted, seen.accepted);
               check_field("energy_now", $signed(want.energy), $signed(seen.energy));
               check_field("magnetisation_now", $signed(want.magnet), $signed(seen.magnet));
               check_field("accepts_now", want.accepts, seen.accepts);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_flip(req_tdata[SITE_W-1:0], req_tdata[SITE_W +: RAND_W],
                         req_tdata[SITE_W + RAND_W], want);
            results_due = {results_due, want};
         end
      end
      outstanding <= results_due.size();
      failures    <= fail_count;
   end

endmodule

// ===== verif/ising_metropolis_spin_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Metropolis spin update testbench
// Drives proposals into the spin update block: a short directed opening on
// wrapped corner sites, then random proposals clustered so that neighbors
// interact, under a series of threshold settings from all-open to all-closed.
// Sender and receiver stall at random in two mixes, then run without stalls.
// A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_tb
   import ising_pkg::*;
();

   localparam int SIDE          = 64;
   localparam int NUM_SETTINGS  = 8;
   localparam int PER_SETTING   = 250;
   localparam int RANDOM_TOTAL  = NUM_SETTINGS * PER_SETTING;
   localparam int MAX_SITE      = 2**SITE_W - 1;
   localparam int MAX_RAND      = 2**RAND_W - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LOW = 3'd5;

   localparam logic [NUM_THR*THR_W-1:0] COLD_THR =
      {16'd0, 16'd0, 16'd3, 16'd162, 16'd8869};
   localparam logic [NUM_THR*THR_W-1:0] CRITICAL_THR =
      {16'd24, 16'd137, 16'd800, 16'd4661, 16'd27146};
   localparam logic [NUM_THR*THR_W-1:0] HOT_THR =
      {16'd1789, 16'd3985, 16'd8869, 16'd19742, 16'd43930};
   localparam logic [NUM_THR*THR_W-1:0] ALTERNATE_THR =
      {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [THR_W-1:0]       csr_data = '0;

   int unsigned outstanding;
   int unsigned failures;
   int          send_idle_pct = 15;
   int          recv_idle_pct = 46;
   int          proposals_sent = 0;
   logic [THR_W-1:0] thr_now [NUM_THR];

   ising_metropolis_spin_update #(.SIDE(SIDE)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   ising_metropolis_spin_update_checker #(.SIDE(SIDE)) check_unit (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .outstanding(outstanding), .failures(failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5ms;
      $display("ising_metropolis_spin_update verification failed");
      $finish;
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   function automatic logic [THR_W-1:0] planned_threshold(input int setting, input int r);
      case (setting)
         0:       return '1;
         1:       return COLD_THR[r*THR_W +: THR_W];
         2:       return CRITICAL_THR[r*THR_W +: THR_W];
         3:       return HOT_THR[r*THR_W +: THR_W];
         5:       return ALTERNATE_THR[r*THR_W +: THR_W];
         7:       return '0;
         default: return THR_W'($urandom_range(MAX_RAND));
      endcase
   endfunction

   task automatic apply_setting(input int setting);
      for (int r = 0; r < NUM_THR; r++) begin
         thr_now[r] = planned_threshold(setting, r);
         write_register(csr_index_type'(r), thr_now[r]);
      end
      for (int u = CSR_UNMAPPED_LOW; u < 2**CSR_IDX_W; u++)
         write_register(CSR_IDX_W'(u), THR_W'($urandom_range(MAX_RAND)));
      csr_valid <= 1'b0;
   endtask

   task automatic send_proposal(input int site, input int rnd, input logic clear);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, clear, RAND_W'(rnd), SITE_W'(site)};
      do @(posedge clock); while (!req_tready);
      proposals_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      int site, rnd, pick, row, col, base_row, base_col, done;
      foreach (thr_now[i])
         thr_now[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // All thresholds closed: only non-positive energy changes are taken.
      send_proposal(0, 0, 1'b0);
      send_proposal(0, MAX_RAND, 1'b0);
      send_proposal(1, MAX_RAND, 1'b0);
      send_proposal(SIDE - 1, 0, 1'b0);
      send_proposal(SIDE, 0, 1'b0);
      send_proposal(MAX_SITE - SIDE + 1, 0, 1'b0);
      send_proposal(MAX_SITE, MAX_RAND, 1'b1);
      send_proposal(0, 0, 1'b0);
      send_proposal(0, 0, 1'b0);
      send_proposal(SIDE + 1, 0, 1'b0);
      wait_drained();

      // All thresholds open: a rise is taken unless the fraction is all ones.
      apply_setting(0);
      send_proposal(0, MAX_RAND, 1'b0);
      send_proposal(0, MAX_RAND - 1, 1'b0);
      send_proposal(MAX_SITE, MAX_RAND - 1, 1'b0);
      send_proposal(MAX_SITE, MAX_RAND, 1'b0);
      send_proposal(SIDE + 1, 0, 1'b1);
      send_proposal(SIDE + 1, MAX_RAND - 1, 1'b0);

      done = 0;
      site = 0;
      for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
         if (setting != 0) begin
            wait_drained();
            apply_setting(setting);
         end
         base_row = (setting % 2 == 0) ? SIDE - 3 : $urandom_range(SIDE - 1);
         base_col = (setting % 3 == 0) ? SIDE - 2 : $urandom_range(SIDE - 1);
         for (int n = 0; n < PER_SETTING; n++) begin
            if (done < RANDOM_TOTAL / 3) begin
               send_idle_pct = 15;
               recv_idle_pct = 46;
            end else if (done < 2 * RANDOM_TOTAL / 3) begin
               send_idle_pct = 46;
               recv_idle_pct = 15;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            row  = site / SIDE;
            col  = site % SIDE;
            if (pick < 55) begin
               row = (base_row + $urandom_range(5)) % SIDE;
               col = (base_col + $urandom_range(5)) % SIDE;
               site = row * SIDE + col;
            end else if (pick < 80) begin
               case ($urandom_range(4))
                  0: row = (row + SIDE - 1) % SIDE;
                  1: row = (row + 1) % SIDE;
                  2: col = (col + SIDE - 1) % SIDE;
                  3: col = (col + 1) % SIDE;
                  default: ;
               endcase
               site = row * SIDE + col;
            end else begin
               site = $urandom_range(MAX_SITE);
            end
            pick = $urandom_range(99);
            if (pick < 10)
               rnd = int'(RAND_W'(thr_now[$urandom_range(NUM_THR - 1)] + $urandom_range(2) - 1));
            else if (pick < 15)
               rnd = $urandom_range(1) ? MAX_RAND : 0;
            else
               rnd = $urandom_range(MAX_RAND);
            send_proposal(site, rnd, $urandom_range(99) < 3);
            done++;
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d proposals under %0d threshold settings, with ignored register",
               proposals_sent, NUM_SETTINGS + 1);
      $display("writes, both stall mixes and a stall-free stretch; %0d failures.", failures);
      if (failures == 0)
         $display("ising_metropolis_spin_update verification clean");
      else
         $display("ising_metropolis_spin_update verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ising_pkg.sv
design/ising_metropolis_spin_update.sv
verif/ising_metropolis_spin_update_checker.sv
verif/ising_metropolis_spin_update_tb.sv
